// ----- design/cap_pkg.sv -----
package cap_pkg;

   localparam int MAX_CLASSES  = 32;
   localparam int COUNT_BITS   = 20;
   localparam int PALETTE_SIZE = 20;

   localparam int SCORE_BITS = 16;
   localparam int CSR_BITS   = 6;
   localparam int CLASS_BITS = $clog2(MAX_CLASSES);
   localparam int PAL_BITS   = $clog2(PALETTE_SIZE);
   localparam int SLOT_BITS  = (CLASS_BITS > PAL_BITS) ? CLASS_BITS : PAL_BITS;
   localparam int WRAP_STEPS = (MAX_CLASSES + PALETTE_SIZE - 1) / PALETTE_SIZE;

   localparam int RSP_FIELD_BITS = CLASS_BITS + 24 + COUNT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // -1.0 in Q8.8
   localparam logic signed [SCORE_BITS-1:0] SCORE_START = -SCORE_BITS'(256);

   localparam logic KIND_LABEL = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   // {channel 0, channel 1, channel 2}
   localparam logic [23:0] PALETTE [PALETTE_SIZE] = '{
      24'h800000, 24'h008000, 24'h000080, 24'h808000,
      24'h800080, 24'h008080, 24'hC00000, 24'h00C000,
      24'h0000C0, 24'hC0C000, 24'hC000C0, 24'h00C0C0,
      24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
      24'hFF00FF, 24'h00FFFF, 24'h808080, 24'hFFFFFF
   };

   typedef struct packed {
      logic take;        // request accepted
      logic rd_label;    // read histogram entry of the label
      logic put_label;   // bump entry, load label result
      logic rd_dump;     // read histogram entry of the dump index
      logic put_count;   // load histogram result, advance dump index
   } cap_cmd_type;

   typedef struct packed {
      logic pixel_end;   // current request closes its pixel
      logic frame_end;   // held frame end of the closed pixel
      logic out_free;    // result register can take a result
      logic dump_last;   // dump index is at the last class
   } cap_stat_type;

   function automatic logic [23:0] palette_rgb(input logic [CLASS_BITS-1:0] label);
      logic [SLOT_BITS-1:0] slot;
      slot = SLOT_BITS'(label);
      for (int i = 0; i < WRAP_STEPS; i++) begin
         if (slot >= SLOT_BITS'(PALETTE_SIZE)) begin
            slot = slot - SLOT_BITS'(PALETTE_SIZE);
         end
      end
      return PALETTE[PAL_BITS'(slot)];
   endfunction

endpackage

// ----- design/cap_ram.sv -----
module cap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/cap_datapath.sv -----
module cap_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [15:0]                        req_tdata,
   input  logic                               req_tlast,
   input  logic                               csr_wr_en,
   input  logic [cap_pkg::CSR_BITS-1:0]       csr_wr_data,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [cap_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tuser,
   input  cap_pkg::cap_cmd_type               cmd,
   output cap_pkg::cap_stat_type              stat
);

   localparam int CB = cap_pkg::CLASS_BITS;
   localparam int SB = cap_pkg::SCORE_BITS;
   localparam int NB = cap_pkg::CSR_BITS;
   localparam int KB = cap_pkg::COUNT_BITS;
   localparam int DB = cap_pkg::RSP_DATA_BITS;

   logic [NB-1:0]        csr_ff, csr_in;
   logic signed [SB-1:0] best_ff, best_in;
   logic [CB-1:0]        bclass_ff, bclass_in;
   logic [CB-1:0]        idx_ff, idx_in;
   logic [CB-1:0]        label_ff, label_in;
   logic                 fe_ff, fe_in;
   logic [NB-1:0]        n_ff, n_in;
   logic [CB-1:0]        didx_ff, didx_in;
   logic [cap_pkg::MAX_CLASSES-1:0] valid_ff, valid_in;

   logic          rv_ff, rv_in;
   logic          kind_ff, kind_in;
   logic [CB-1:0] rcls_ff, rcls_in;
   logic [23:0]   rgb_ff, rgb_in;
   logic [KB-1:0] rcnt_ff, rcnt_in;
   logic          rlast_ff, rlast_in;

   logic signed [SB-1:0] score;
   logic [NB-1:0]        n_eff;
   logic                 better;
   logic [CB-1:0]        winner;
   logic [KB-1:0]        ram_q, label_cnt, dump_cnt, label_inc;
   logic [CB-1:0]        rd_addr;

   assign score  = $signed(req_tdata[SB-1:0]);
   assign better = score > best_ff;
   assign winner = better ? idx_ff : bclass_ff;

   always_comb begin
      n_eff = csr_ff;
      if (csr_ff == '0) begin
         n_eff = NB'(1);
      end else if (csr_ff > NB'(cap_pkg::MAX_CLASSES)) begin
         n_eff = NB'(cap_pkg::MAX_CLASSES);
      end
   end

   assign rd_addr   = cmd.rd_label ? label_ff : didx_ff;
   assign label_cnt = valid_ff[label_ff] ? ram_q : '0;
   assign dump_cnt  = valid_ff[didx_ff] ? ram_q : '0;
   assign label_inc = (label_cnt == '1) ? label_cnt : label_cnt + KB'(1);

   cap_ram #(
      .WIDTH (KB),
      .DEPTH (cap_pkg::MAX_CLASSES)
   ) u_hist (
      .clock   (clock),
      .wr_en   (cmd.put_label),
      .wr_addr (label_ff),
      .wr_data (label_inc),
      .rd_en   (cmd.rd_label | cmd.rd_dump),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign stat.pixel_end = ((NB'(idx_ff) + NB'(1)) >= n_eff) || req_tlast;
   assign stat.frame_end = fe_ff;
   assign stat.out_free  = !rv_ff || rsp_tready;
   assign stat.dump_last = (NB'(didx_ff) + NB'(1)) == n_ff;

   always_comb begin
      csr_in    = csr_wr_en ? csr_wr_data : csr_ff;
      best_in   = best_ff;
      bclass_in = bclass_ff;
      idx_in    = idx_ff;
      label_in  = label_ff;
      fe_in     = fe_ff;
      n_in      = n_ff;
      didx_in   = didx_ff;
      valid_in  = valid_ff;
      rv_in     = rv_ff && !rsp_tready;
      kind_in   = kind_ff;
      rcls_in   = rcls_ff;
      rgb_in    = rgb_ff;
      rcnt_in   = rcnt_ff;
      rlast_in  = rlast_ff;

      if (cmd.take) begin
         if (stat.pixel_end) begin
            best_in   = cap_pkg::SCORE_START;
            bclass_in = '0;
            idx_in    = '0;
            label_in  = winner;
            fe_in     = req_tlast;
            n_in      = n_eff;
            didx_in   = '0;
         end else begin
            best_in   = better ? score : best_ff;
            bclass_in = winner;
            idx_in    = idx_ff + CB'(1);
         end
      end

      if (cmd.put_label) begin
         valid_in[label_ff] = 1'b1;
         rv_in    = 1'b1;
         kind_in  = cap_pkg::KIND_LABEL;
         rcls_in  = label_ff;
         rgb_in   = cap_pkg::palette_rgb(label_ff);
         rcnt_in  = '0;
         rlast_in = !fe_ff;
      end

      if (cmd.put_count) begin
         rv_in    = 1'b1;
         kind_in  = cap_pkg::KIND_COUNT;
         rcls_in  = didx_ff;
         rgb_in   = '0;
         rcnt_in  = dump_cnt;
         rlast_in = stat.dump_last;
         didx_in  = didx_ff + CB'(1);
         if (stat.dump_last) begin
            valid_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff    <= NB'(1);
         best_ff   <= cap_pkg::SCORE_START;
         bclass_ff <= '0;
         idx_ff    <= '0;
         valid_ff  <= '0;
         rv_ff     <= 1'b0;
      end else begin
         csr_ff    <= csr_in;
         best_ff   <= best_in;
         bclass_ff <= bclass_in;
         idx_ff    <= idx_in;
         valid_ff  <= valid_in;
         rv_ff     <= rv_in;
      end
      label_ff <= label_in;
      fe_ff    <= fe_in;
      n_ff     <= n_in;
      didx_ff  <= didx_in;
      kind_ff  <= kind_in;
      rcls_ff  <= rcls_in;
      rgb_ff   <= rgb_in;
      rcnt_ff  <= rcnt_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tdata  = DB'({rcnt_ff, rgb_ff[7:0], rgb_ff[15:8], rgb_ff[23:16], rcls_ff});

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.put_label || cmd.put_count) |-> stat.out_free)
      else $error("result loaded over an untaken result");

   a_hist_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.put_count && stat.dump_last) |=> (valid_ff == '0))
      else $error("histogram not cleared after dump");

   a_pixel_restart: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && stat.pixel_end) |=> (idx_ff == '0 && best_ff == cap_pkg::SCORE_START))
      else $error("running maximum not restarted at pixel end");
`endif

endmodule

// ----- design/cap_ctrl.sv -----
module cap_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  cap_pkg::cap_stat_type stat,
   output cap_pkg::cap_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LRD,
      ST_LWR,
      ST_DRD,
      ST_DOUT
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.take = 1'b1;
               if (stat.pixel_end) begin
                  state_in = ST_LRD;
               end
            end
         end
         ST_LRD: begin
            cmd.rd_label = 1'b1;
            state_in     = ST_LWR;
         end
         ST_LWR: begin
            if (stat.out_free) begin
               cmd.put_label = 1'b1;
               state_in      = stat.frame_end ? ST_DRD : ST_IDLE;
            end
         end
         ST_DRD: begin
            cmd.rd_dump = 1'b1;
            state_in    = ST_DOUT;
         end
         ST_DOUT: begin
            if (stat.out_free) begin
               cmd.put_count = 1'b1;
               state_in      = stat.dump_last ? ST_IDLE : ST_DRD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_pixel_end_goes_read: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && stat.pixel_end) |=> (state_ff == ST_LRD))
      else $error("pixel end did not start histogram update");

   a_dump_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.put_count && stat.dump_last) |=> req_tready)
      else $error("dump did not return to idle");

   a_take_when_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> req_tready)
      else $error("request taken while not ready");
`endif

endmodule

// ----- design/class_argmax_palette_histogram.sv -----
// A score that does not close its pixel keeps the block ready, so a new score is taken every cycle
// until a pixel closes. A pixel's closing score has its label result loaded onto rsp after a histogram
// read state and a read-modify-write state that waits for a free result register; the next request is taken
// once that result is loaded. A frame end first adds a dump, one RAM read and one load per class, class_count entries.
// Reset: class_count 1, running maximum -1.0, histogram cleared at once through its valid bits.
module class_argmax_palette_histogram (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // score
   input  logic                              req_tlast,   // frame_end
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // class_id, color_first, color_second, color_third, pixel_count, zero fill
   output logic [cap_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                              rsp_tlast,   // last
   output logic                              rsp_tuser,   // kind
   // class_count register
   input  logic                              csr_wr_en,
   input  logic [cap_pkg::CSR_BITS-1:0]      csr_wr_data
);

   cap_pkg::cap_cmd_type  cmd;
   cap_pkg::cap_stat_type stat;

   // Sequencer: accept scores, run the histogram update and the frame-end dump.
   cap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Running maximum, histogram RAM, palette lookup and result register.
   cap_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

// ----- sim/argmax_histogram_checker.sv -----
module argmax_histogram_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // score
   input  logic                              req_tlast,   // frame_end
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // class_id, color_first, color_second, color_third, pixel_count, zero fill
   input  logic [cap_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                              rsp_tlast,   // last
   input  logic                              rsp_tuser,   // kind
   input  logic                              csr_wr_en,
   input  logic [cap_pkg::CSR_BITS-1:0]      csr_wr_data,
   output int                                mismatches,
   output int                                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ID_LO    = 0;
   localparam int CH0_LO   = ID_LO + cap_pkg::CLASS_BITS;
   localparam int CH1_LO   = CH0_LO + 8;
   localparam int CH2_LO   = CH1_LO + 8;
   localparam int COUNT_LO = CH2_LO + 8;
   localparam logic [cap_pkg::COUNT_BITS-1:0] COUNT_FULL = '1;

   typedef struct packed {
      logic                          kind;
      logic [cap_pkg::CLASS_BITS-1:0] class_id;
      logic [7:0]                    ch0;
      logic [7:0]                    ch1;
      logic [7:0]                    ch2;
      logic [cap_pkg::COUNT_BITS-1:0] pixel_count;
      logic                          last;
   } seg_result_type;

   seg_result_type                  awaited[$];
   logic [cap_pkg::CSR_BITS-1:0]    class_count_reg;
   logic signed [15:0]              run_best;
   logic [cap_pkg::CLASS_BITS-1:0]  run_class;
   int unsigned                     class_pos;
   logic [cap_pkg::COUNT_BITS-1:0]  label_hist [cap_pkg::MAX_CLASSES];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic int unsigned scores_per_pixel(input logic [cap_pkg::CSR_BITS-1:0] v);
      if (v == 0) begin
         return 1;
      end
      if (v > cap_pkg::MAX_CLASSES) begin
         return cap_pkg::MAX_CLASSES;
      end
      return 32'(v);
   endfunction

   // channel 0 in the top byte
   function automatic logic [23:0] shade_of(input logic [cap_pkg::CLASS_BITS-1:0] label);
      case (label % 20)
         0:       return 24'h800000;
         1:       return 24'h008000;
         2:       return 24'h000080;
         3:       return 24'h808000;
         4:       return 24'h800080;
         5:       return 24'h008080;
         6:       return 24'hC00000;
         7:       return 24'h00C000;
         8:       return 24'h0000C0;
         9:       return 24'hC0C000;
         10:      return 24'hC000C0;
         11:      return 24'h00C0C0;
         12:      return 24'hFF0000;
         13:      return 24'h00FF00;
         14:      return 24'h0000FF;
         15:      return 24'hFFFF00;
         16:      return 24'hFF00FF;
         17:      return 24'h00FFFF;
         18:      return 24'h808080;
         default: return 24'hFFFFFF;
      endcase
   endfunction

   task automatic restart_pixel();
      run_best  = cap_pkg::SCORE_START;
      run_class = '0;
      class_pos = 0;
   endtask

   task automatic take_score(input logic [15:0] raw, input logic frame_end);
      int unsigned                    n;
      logic [cap_pkg::CLASS_BITS-1:0] lbl;
      logic [23:0]                    rgb;
      seg_result_type                 r;
      n = scores_per_pixel(class_count_reg);
      if ($signed(raw) > run_best) begin
         run_best  = raw;
         run_class = class_pos[cap_pkg::CLASS_BITS-1:0];
      end
      class_pos++;
      if (class_pos >= n || frame_end) begin
         lbl = run_class;
         if (label_hist[lbl] != COUNT_FULL) begin
            label_hist[lbl]++;
         end
         rgb           = shade_of(lbl);
         r.kind        = cap_pkg::KIND_LABEL;
         r.class_id    = lbl;
         r.ch0         = rgb[23:16];
         r.ch1         = rgb[15:8];
         r.ch2         = rgb[7:0];
         r.pixel_count = '0;
         r.last        = !frame_end;
         awaited.push_back(r);
         restart_pixel();
      end
      if (frame_end) begin
         for (int c = 0; c < n; c++) begin
            r.kind        = cap_pkg::KIND_COUNT;
            r.class_id    = c[cap_pkg::CLASS_BITS-1:0];
            r.ch0         = '0;
            r.ch1         = '0;
            r.ch2         = '0;
            r.pixel_count = label_hist[c];
            r.last        = (c == n - 1);
            awaited.push_back(r);
         end
         foreach (label_hist[i]) label_hist[i] = '0;
      end
   endtask

   task automatic check_field(input string name, input longint unsigned want, got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      seg_result_type want;
      if (reset) begin
         class_count_reg = 1;
         restart_pixel();
         foreach (label_hist[i]) label_hist[i] = '0;
         awaited.delete();
      end else begin
         if (csr_wr_en) begin
            class_count_reg = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            take_score(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited.size() == 0) begin
               $error("result with nothing awaited: kind %0d, class_id %0d",
                      rsp_tuser, rsp_tdata[ID_LO +: cap_pkg::CLASS_BITS]);
               mismatches++;
            end else begin
               want = awaited.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("class_id", want.class_id,
                           rsp_tdata[ID_LO +: cap_pkg::CLASS_BITS]);
               check_field("color_first", want.ch0, rsp_tdata[CH0_LO +: 8]);
               check_field("color_second", want.ch1, rsp_tdata[CH1_LO +: 8]);
               check_field("color_third", want.ch2, rsp_tdata[CH2_LO +: 8]);
               check_field("pixel_count", want.pixel_count,
                           rsp_tdata[COUNT_LO +: cap_pkg::COUNT_BITS]);
               check_field("last", want.last, rsp_tlast);
            end
         end
      end
      outstanding <= awaited.size();
   end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // a cycle without any request, result or register write counts towards the limit;
   // the longest honest silence is a long sender gap or a long receiver stall
   localparam int WATCHDOG_LIMIT = 2000;
   // a score that does not close its pixel is finished once its running-maximum registers take it
   localparam int SETTLE_CYCLES  = 4;
   localparam int RANDOM_ITEMS   = 330;

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              req_tvalid  = 1'b0;
   logic                              req_tready;
   logic [15:0]                       req_tdata   = '0;
   logic                              req_tlast   = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready  = 1'b0;
   logic [cap_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                              rsp_tlast;
   logic                              rsp_tuser;
   logic                              csr_wr_en   = 1'b0;
   logic [cap_pkg::CSR_BITS-1:0]      csr_wr_data = '0;

   int mismatches;
   int outstanding;
   int idle_cycles  = 0;
   int rsp_hold     = 0;
   bit steady_send  = 1'b0;
   bit steady_ready = 1'b0;

   class_argmax_palette_histogram dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   argmax_histogram_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Gap length: mostly none, often a few cycles, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Scores biased towards the interesting corners: the -1.0 starting point and its
   // neighbours, the Q8.8 extremes, small values and a repeat of the previous score
   // so that ties turn up inside a pixel.
   function automatic logic [15:0] pick_score(input logic [15:0] prev);
      case ($urandom_range(0, 7))
         0:       return 16'hFF00;
         1:       return 16'hFEFF + 16'($urandom_range(0, 2));
         2:       return prev;
         3:       return 16'h7FFF;
         4:       return 16'h8000;
         5:       return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int scores_per_pixel(input logic [cap_pkg::CSR_BITS-1:0] v);
      if (v == 0) begin
         return 1;
      end
      if (v > cap_pkg::MAX_CLASSES) begin
         return cap_pkg::MAX_CLASSES;
      end
      return 32'(v);
   endfunction

   // Offer one score; return at the edge that takes it, with valid still up so that
   // a back-to-back request needs no extra assignment in the same step.
   task automatic send_score(input logic [15:0] score, input logic frame_end);
      int gap;
      gap = steady_send ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= score;
      req_tlast  <= frame_end;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid, hold until every predicted result is back, then let the block settle
   // from any score that produces no result of its own.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_class_count(input logic [cap_pkg::CSR_BITS-1:0] value);
      wait_for_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Receiver: random stalls, with the odd long stretch of constant readiness.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!steady_ready && $urandom_range(0, 3) == 0) begin
               rsp_hold = pick_gap();
            end
         end
         if ($urandom_range(0, 199) == 0) begin
            steady_ready = !steady_ready;
         end
      end
   end

   // Watchdog: end the run when nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("class_argmax_palette_histogram regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int          sent;
      int          n;
      int          frames;
      int          pixels;
      int          len;
      int          tail;
      int          pick;
      logic [5:0]  count_value;
      logic [15:0] score;

      score = '0;
      sent  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // Reset count of one: every score closes its pixel; extremes of the score field.
      send_score(16'h7FFF, 1'b0);
      send_score(16'h8000, 1'b1);

      // A count of zero behaves as one; exactly -1.0 never beats the starting best.
      write_class_count(6'd0);
      send_score(16'h0000, 1'b0);
      send_score(16'hFF00, 1'b1);

      // Three classes: a tie keeps the lower class, then a pixel won by the last class.
      write_class_count(6'd3);
      send_score(16'h0100, 1'b0);
      send_score(16'h0200, 1'b0);
      send_score(16'h0200, 1'b0);
      send_score(16'h8000, 1'b0);
      send_score(16'h8001, 1'b0);
      send_score(16'h7FFF, 1'b1);

      // All ones in the register clamps to the maximum; the frame ends after three
      // scores, so the label comes from a partial pixel and the dump covers every class.
      write_class_count(6'h3F);
      send_score(16'hFF01, 1'b0);
      send_score(16'hFF00, 1'b0);
      send_score(16'h0001, 1'b1);

      // Lower the count mid-pixel: the next score is past the new count and closes it.
      write_class_count(6'd5);
      send_score(16'h1234, 1'b0);
      send_score(16'h4321, 1'b0);
      send_score(16'hFFFF, 1'b0);
      write_class_count(6'd2);
      send_score(16'h0000, 1'b0);
      send_score(16'hFEFF, 1'b1);

      // Just above the maximum also clamps.
      write_class_count(6'd33);
      send_score(16'hAAAA, 1'b0);
      send_score(16'h5555, 1'b1);

      // --- random part: phases with one count each ---
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 11);
         case (pick)
            0:       count_value = 6'd0;
            1:       count_value = 6'h3F;
            2:       count_value = 6'd33;
            3:       count_value = 6'd32;
            4:       count_value = 6'($urandom_range(9, 31));
            5:       count_value = 6'($urandom_range(34, 62));
            default: count_value = 6'($urandom_range(1, 8));
         endcase
         write_class_count(count_value);
         n           = scores_per_pixel(count_value);
         steady_send = ($urandom_range(0, 3) == 0);
         frames      = $urandom_range(1, 3);

         for (int f = 0; f < frames; f++) begin
            pixels = (n > 16) ? $urandom_range(1, 2) : $urandom_range(1, 4);
            for (int p = 0; p < pixels; p++) begin
               len = n;
               // now and then cut the frame short inside its last pixel
               if (p == pixels - 1 && $urandom_range(0, 5) == 0) begin
                  len = $urandom_range(1, n);
               end
               for (int i = 0; i < len; i++) begin
                  score = pick_score(score);
                  send_score(score, (p == pixels - 1) && (i == len - 1));
                  sent++;
               end
               // occasionally hold the sender until every result has drained
               if ($urandom_range(0, 9) == 0) begin
                  wait_for_quiet();
               end
            end
         end

         // leave a pixel half done so that the next count takes over mid-pixel
         if (n > 1 && $urandom_range(0, 3) == 0) begin
            tail = $urandom_range(1, n - 1);
            for (int i = 0; i < tail; i++) begin
               score = pick_score(score);
               send_score(score, 1'b0);
               sent++;
            end
         end
      end

      // drain, then watch a little longer for stray results
      wait_for_quiet();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("class_argmax_palette_histogram regression: pass");
      end else begin
         $display("class_argmax_palette_histogram regression: fail");
      end
      $finish;
   end

endmodule
